// ----- sv/sparse_polynomial_adder_assert.svh -----
// Assertion macros used by the sparse polynomial adder datapath.
// Each one expects clk_i and rst_ni to be visible where it is used.
`ifndef SPARSE_POLYNOMIAL_ADDER_ASSERT_SVH
`define SPARSE_POLYNOMIAL_ADDER_ASSERT_SVH

// Check a property on every rising clock edge while out of reset.
`define SPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds.
`define SPA_ASSERT_NEVER(lbl, cond, msg) \
  `SPA_ASSERT(lbl, !(cond), msg)

`endif

// ----- sv/spa_pkg.sv -----
package spa_pkg;

  localparam int unsigned EXP_W  = 8;
  localparam int unsigned COEF_W = 32;
  localparam int unsigned TERM_W = EXP_W + COEF_W;
  localparam int unsigned OP_W   = 2;

  // Operation codes carried on the input tuser
  localparam logic [OP_W-1:0] OP_LOAD_FIRST  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_SECOND = 2'd1;
  localparam logic [OP_W-1:0] OP_ADD         = 2'd2;

  localparam logic [COEF_W-1:0] COEF_MAX = 32'h7FFF_FFFF;
  localparam logic [COEF_W-1:0] COEF_MIN = 32'h8000_0000;

  typedef struct packed {
    logic load_first;
    logic load_second;
    logic step;
    logic flush;
  } ctl_cmd_t;

  typedef struct packed {
    logic a_left;
    logic b_left;
    logic out_free;
  } ctl_sts_t;

endpackage

// ----- sv/spa_ram.sv -----
module spa_ram #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   wr_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]                       wr_data_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]                       rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- sv/spa_ctrl.sv -----
module spa_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [spa_pkg::OP_W-1:0]      op_i,
  output logic                          in_ready_o,
  input  spa_pkg::ctl_sts_t             sts_i,
  output spa_pkg::ctl_cmd_t             cmd_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StMerge = 2'd1;
  localparam logic [1:0] StFlush = 2'd2;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (accept) begin
          case (op_i)
            spa_pkg::OP_LOAD_FIRST:  cmd_o.load_first  = 1'b1;
            spa_pkg::OP_LOAD_SECOND: cmd_o.load_second = 1'b1;
            spa_pkg::OP_ADD:         state_d = StMerge;
            default: ;
          endcase
        end
      end
      StMerge: begin
        // advance one merge step per free output slot until both lists run dry
        if (!sts_i.a_left && !sts_i.b_left) begin
          state_d = StFlush;
        end else if (sts_i.out_free) begin
          cmd_o.step = 1'b1;
        end
      end
      StFlush: begin
        if (sts_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- sv/spa_datapath.sv -----
module spa_datapath #(
  parameter int unsigned MAX_TERMS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [spa_pkg::EXP_W-1:0]          exponent_i,
  input  logic signed [spa_pkg::COEF_W-1:0]  coefficient_i,
  input  spa_pkg::ctl_cmd_t                  cmd_i,
  output spa_pkg::ctl_sts_t                  sts_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [spa_pkg::EXP_W-1:0]          result_exponent_o,
  output logic signed [spa_pkg::COEF_W-1:0]  result_coefficient_o,
  output logic                               last_term_o,
  output logic                               empty_result_o,
  output logic                               capacity_overflow_o
);

  `include "sparse_polynomial_adder_assert.svh"

  localparam int unsigned CW = $clog2(MAX_TERMS + 1);
  localparam int unsigned AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int unsigned EW = spa_pkg::EXP_W;
  localparam int unsigned KW = spa_pkg::COEF_W;

  logic [CW-1:0] cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic [CW-1:0] ptr_a_q, ptr_a_d, ptr_b_q, ptr_b_d;
  logic          dropped_q, dropped_d;
  logic          wr_a, wr_b;
  logic [spa_pkg::TERM_W-1:0] term_wr, term_a, term_b;

  logic [EW-1:0]        ea, eb;
  logic signed [KW-1:0] ca, cb;
  logic signed [KW:0]   sum_w;
  logic [KW-1:0]        sum_sat;
  logic                 a_left, b_left, take_a, take_b, equal, produce;
  logic [EW-1:0]        new_exp;
  logic [KW-1:0]        new_coef;

  logic          pend_valid_q;
  logic [EW-1:0] pend_exp_q;
  logic [KW-1:0] pend_coef_q;

  logic          out_valid_q, out_load;
  logic [EW-1:0] out_exp_q;
  logic [KW-1:0] out_coef_q;
  logic          out_last_q, out_empty_q, out_cap_q;

  // ---------------------------------------------------------------------------
  // Term stores
  // ---------------------------------------------------------------------------
  assign term_wr = {coefficient_i, exponent_i};
  assign wr_a    = cmd_i.load_first  && (cnt_a_q < CW'(MAX_TERMS));
  assign wr_b    = cmd_i.load_second && (cnt_b_q < CW'(MAX_TERMS));

  // read at the next pointer so the data lines up with the pointer register
  spa_ram #(.WIDTH(spa_pkg::TERM_W), .DEPTH(MAX_TERMS)) u_ram_a (
    .clk_i     (clk_i),
    .wr_en_i   (wr_a),
    .wr_addr_i (cnt_a_q[AW-1:0]),
    .wr_data_i (term_wr),
    .rd_addr_i (ptr_a_d[AW-1:0]),
    .rd_data_o (term_a)
  );

  spa_ram #(.WIDTH(spa_pkg::TERM_W), .DEPTH(MAX_TERMS)) u_ram_b (
    .clk_i     (clk_i),
    .wr_en_i   (wr_b),
    .wr_addr_i (cnt_b_q[AW-1:0]),
    .wr_data_i (term_wr),
    .rd_addr_i (ptr_b_d[AW-1:0]),
    .rd_data_o (term_b)
  );

  // ---------------------------------------------------------------------------
  // Merge step
  // ---------------------------------------------------------------------------
  assign ea     = term_a[EW-1:0];
  assign ca     = term_a[spa_pkg::TERM_W-1:EW];
  assign eb     = term_b[EW-1:0];
  assign cb     = term_b[spa_pkg::TERM_W-1:EW];
  assign a_left = (ptr_a_q < cnt_a_q);
  assign b_left = (ptr_b_q < cnt_b_q);

  assign sum_w   = {ca[KW-1], ca} + {cb[KW-1], cb};
  assign sum_sat = (sum_w[KW] != sum_w[KW-1]) ?
                   (sum_w[KW] ? spa_pkg::COEF_MIN : spa_pkg::COEF_MAX) : sum_w[KW-1:0];

  always_comb begin
    take_a = 1'b0;
    take_b = 1'b0;
    equal  = 1'b0;
    if (a_left && b_left) begin
      take_a = (ea > eb);
      take_b = (ea < eb);
      equal  = (ea == eb);
    end else begin
      take_a = a_left;
      take_b = b_left;
    end
  end

  assign produce  = !(equal && (sum_sat == '0));
  assign new_exp  = take_b ? eb : ea;
  assign new_coef = take_a ? ca : (take_b ? cb : sum_sat);

  // ---------------------------------------------------------------------------
  // Counters and pointers
  // ---------------------------------------------------------------------------
  always_comb begin
    cnt_a_d   = cnt_a_q;
    cnt_b_d   = cnt_b_q;
    ptr_a_d   = ptr_a_q;
    ptr_b_d   = ptr_b_q;
    dropped_d = dropped_q;
    if (wr_a) cnt_a_d = cnt_a_q + CW'(1);
    if (wr_b) cnt_b_d = cnt_b_q + CW'(1);
    if ((cmd_i.load_first && !wr_a) || (cmd_i.load_second && !wr_b)) begin
      dropped_d = 1'b1;
    end
    if (cmd_i.step && (take_a || equal)) ptr_a_d = ptr_a_q + CW'(1);
    if (cmd_i.step && (take_b || equal)) ptr_b_d = ptr_b_q + CW'(1);
    if (cmd_i.flush) begin
      cnt_a_d   = '0;
      cnt_b_d   = '0;
      ptr_a_d   = '0;
      ptr_b_d   = '0;
      dropped_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_a_q   <= '0;
      cnt_b_q   <= '0;
      ptr_a_q   <= '0;
      ptr_b_q   <= '0;
      dropped_q <= 1'b0;
    end else begin
      cnt_a_q   <= cnt_a_d;
      cnt_b_q   <= cnt_b_d;
      ptr_a_q   <= ptr_a_d;
      ptr_b_q   <= ptr_b_d;
      dropped_q <= dropped_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Pending term and output register: hold one term back so the final one
  // can be marked last once the merge is known to be done.
  // ---------------------------------------------------------------------------
  assign out_load = (cmd_i.step && produce && pend_valid_q) || cmd_i.flush;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.step && produce) begin
        pend_valid_q <= 1'b1;
      end else if (cmd_i.flush) begin
        pend_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step && produce) begin
      pend_exp_q  <= new_exp;
      pend_coef_q <= new_coef;
    end
    if (out_load) begin
      out_exp_q   <= pend_valid_q ? pend_exp_q  : '0;
      out_coef_q  <= pend_valid_q ? pend_coef_q : '0;
      out_last_q  <= cmd_i.flush;
      out_empty_q <= cmd_i.flush && !pend_valid_q;
      out_cap_q   <= dropped_q;
    end
  end

  assign sts_o.a_left   = a_left;
  assign sts_o.b_left   = b_left;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o          = out_valid_q;
  assign result_exponent_o    = out_exp_q;
  assign result_coefficient_o = out_coef_q;
  assign last_term_o          = out_last_q;
  assign empty_result_o       = out_empty_q;
  assign capacity_overflow_o  = out_cap_q;

  `SPA_ASSERT(ptr_a_in_range, (ptr_a_q <= cnt_a_q) && (ptr_b_q <= cnt_b_q), "pointer past count")
  `SPA_ASSERT(cnt_in_range, (cnt_a_q <= CW'(MAX_TERMS)) && (cnt_b_q <= CW'(MAX_TERMS)), "count past capacity")
  `SPA_ASSERT_NEVER(no_overwrite, out_valid_q && !out_ready_i && out_load, "stalled word overwritten")
  `SPA_ASSERT(flush_clears, cmd_i.flush |=> (cnt_a_q == '0) && (cnt_b_q == '0) && !dropped_q && !pend_valid_q, "stores not cleared after add")

endmodule

// ----- sv/sparse_polynomial_adder.sv -----
// Sparse polynomial adder. Load the terms of two polynomials one word each
// (tuser 0 appends to the first list, 1 to the second, in descending exponent
// order), then send tuser 2 to merge them: equal exponents are summed with
// Q16.16 saturation and zero sums are dropped. A term loaded into a full list
// is dropped and flagged on every word of the next result. An add is accepted
// while idle, then runs one merge step per free output slot (at most first
// count plus second count steps, each reading one term from each
// single-read-port term memory), sees that both lists are used up and emits
// the final word, stalling while the output is back-pressured. An empty sum
// gives one word flagged empty. After an add both lists and the drop flag are
// clear.
module sparse_polynomial_adder #(
  parameter int unsigned MAX_TERMS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [7:0] exponent, [39:8] coefficient
  input  logic [1:0]  s_axis_tuser,   // [1:0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [7:0] result_exponent, [39:8] result_coefficient
  output logic        m_axis_tlast,   // last_term
  output logic [1:0]  m_axis_tuser    // [0] empty_result, [1] capacity_overflow
);

  spa_pkg::ctl_cmd_t cmd;
  spa_pkg::ctl_sts_t sts;

  logic [spa_pkg::EXP_W-1:0]         res_exp;
  logic signed [spa_pkg::COEF_W-1:0] res_coef;
  logic                              res_empty, res_cap;

  spa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .op_i       (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  spa_datapath #(.MAX_TERMS(MAX_TERMS)) u_datapath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .exponent_i           (s_axis_tdata[7:0]),
    .coefficient_i        (s_axis_tdata[39:8]),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .out_valid_o          (m_axis_tvalid),
    .out_ready_i          (m_axis_tready),
    .result_exponent_o    (res_exp),
    .result_coefficient_o (res_coef),
    .last_term_o          (m_axis_tlast),
    .empty_result_o       (res_empty),
    .capacity_overflow_o  (res_cap)
  );

  assign m_axis_tdata = {res_coef, res_exp};
  assign m_axis_tuser = {res_cap, res_empty};

endmodule
